// ===== rtl/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

    // fixed field widths
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int THRESH_W    = 7;
    localparam int DEC_W       = 2;
    localparam int RSI_BITS    = 15;
    localparam int AVG_FRAC    = 8;

    localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;

    // parameter defaults
    localparam int PRICE_BITS_DEF = 32;
    localparam int MAX_WINDOW_DEF = 255;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_THRESHOLD = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WINDOW_LEN_RESET = 8'd14;
    localparam logic [THRESH_W-1:0]   UPPER_RESET      = 7'd70;
    localparam logic [THRESH_W-1:0]   LOWER_RESET      = 7'd30;

    // decision codes
    localparam logic [DEC_W-1:0] DEC_NONE = 2'd0;
    localparam logic [DEC_W-1:0] DEC_SELL = 2'd1;
    localparam logic [DEC_W-1:0] DEC_BUY  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WARM,
        ST_MUL_G,
        ST_START_G,
        ST_WAIT_G,
        ST_MUL_L,
        ST_START_L,
        ST_WAIT_L,
        ST_MUL_R,
        ST_START_R,
        ST_WAIT_R,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic short_q;   // quotient fits in RSI_BITS
    } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/rsi_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2^Q for the selected quotient length Q.
module rsi_divider import rsi_pkg::*; #(
    parameter int NUM_W  = 57,
    parameter int DEN_W  = 42,
    parameter int QLONG  = 41,
    parameter int QSHORT = 15
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire div_req_t         req,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [QLONG-1:0]      quo
);

    localparam int REMW = DEN_W + 1;
    localparam int CW   = $clog2(QLONG + 1);

    logic [REMW-1:0]  rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [REMW-1:0]  trial;
    logic [REMW:0]    diff;
    logic             qbit;

    assign trial = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign qbit  = ~diff[REMW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= req.short_q ? CW'(QSHORT) : CW'(QLONG);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            // high part seeds the remainder, low Q bits are left-aligned
            rem_reg <= req.short_q ? REMW'(num >> QSHORT) : REMW'(num >> QLONG);
            num_reg <= req.short_q ? (num << (NUM_W - QSHORT)) : (num << (NUM_W - QLONG));
            den_reg <= den;
        end else if (cnt_reg != '0) begin
            rem_reg <= qbit ? diff[REMW-1:0] : trial;
            num_reg <= {num_reg[NUM_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = num_reg[QLONG-1:0];

endmodule

`default_nettype wire

// ===== rtl/rsi_threshold_signal_top.sv =====
`default_nettype none

// Channel   Dir  Bits  Contents (low bit up)
// s_axis    in   32    tdata: close_price (Q16.16)
// m_axis    out  24    tdata: rsi_value[14:0], decision[16:15], zero fill; tuser: rsi_undefined
// cfg       in   8     index 0 window_len, 1 upper_threshold, 2 lower_threshold
//
// The priming item only stores its price; warm-up items add to plain sums. An item that
// yields a result runs the gain, loss and RSI steps in turn, skipping the RSI division when
// both averages are zero. The shared restoring divider (one quotient bit per cycle) and one
// shared multiplier serve all three steps. aresetn is synchronous, active low; a window_len
// write clears state.
// A held result stalls the block only in ST_EMIT, until the output register frees.
module rsi_threshold_signal_top import rsi_pkg::*; #(
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,    // [31:0] close_price
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,    // [14:0] rsi_value, [16:15] decision
    output logic [M_TUSER_W-1:0]        m_tuser,    // [0] rsi_undefined
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int P_W  = (PRICE_BITS < S_TDATA_W) ? PRICE_BITS : S_TDATA_W;
    localparam int WB   = $clog2(MAX_WINDOW + 1);
    localparam int IW   = $clog2(MAX_WINDOW + 2);
    localparam int QL   = P_W + AVG_FRAC + 1;
    localparam int AVW  = (WB > AVG_FRAC + 1) ? P_W + WB : QL;
    localparam int MB   = (WB > RSI_BITS) ? WB : RSI_BITS;
    localparam int PRW  = AVW + MB;
    localparam int DW   = AVW + 1;
    localparam int DN_A = (DW + RSI_BITS > QL + WB) ? DW + RSI_BITS : QL + WB;
    localparam int DN   = (DN_A > PRW + 1) ? DN_A : PRW + 1;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] window_len_reg;
    logic [THRESH_W-1:0]   upper_reg;
    logic [THRESH_W-1:0]   lower_reg;

    logic [P_W-1:0]      prior_close_reg;
    logic [IW-1:0]       items_reg;
    logic [AVW-1:0]      avg_gain_reg;
    logic [AVW-1:0]      avg_loss_reg;
    logic [RSI_BITS-1:0] prior_rsi_reg;
    logic                prior_undef_reg;

    logic [P_W-1:0]      gain_reg;
    logic [P_W-1:0]      loss_reg;
    logic                seed_reg;
    logic [PRW-1:0]      prod_reg;
    logic [DW-1:0]       sum_reg;
    logic [RSI_BITS-1:0] rsi_reg;
    logic                undef_reg;

    logic                m_tvalid_reg;
    logic [RSI_BITS-1:0] m_rsi_reg;
    logic                m_undef_reg;
    logic [DEC_W-1:0]    m_dec_reg;

    logic [WB-1:0]  win_eff;
    logic [IW-1:0]  win_ext;
    logic [P_W-1:0] close;
    logic [P_W-1:0] gain_c;
    logic [P_W-1:0] loss_c;
    logic           accept;
    logic           is_prime;
    logic           is_warm;
    logic           is_seed;
    logic           out_free;
    logic           sum_zero;
    logic [DEC_W-1:0] dec_c;

    logic [AVW-1:0] mul_a;
    logic [MB-1:0]  mul_b;
    logic [PRW-1:0] mul_p;

    div_req_t       div_req;
    logic [DN-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic           div_done;
    logic [QL-1:0]  div_quo;
    logic [P_W-1:0] gl_sel;

    // window clamped to [2, MAX_WINDOW]
    always_comb begin
        if (window_len_reg < CFG_DATA_W'(2)) begin
            win_eff = WB'(2);
        end else if (int'(window_len_reg) > MAX_WINDOW) begin
            win_eff = WB'(MAX_WINDOW);
        end else begin
            win_eff = WB'(window_len_reg);
        end
    end

    assign win_ext  = IW'(win_eff);
    assign close    = s_tdata[P_W-1:0];
    assign gain_c   = (close > prior_close_reg) ? close - prior_close_reg : '0;
    assign loss_c   = (prior_close_reg > close) ? prior_close_reg - close : '0;
    assign accept   = s_tvalid & s_tready;
    assign is_prime = (items_reg == '0);
    assign is_warm  = !is_prime && (items_reg < win_ext);
    assign is_seed  = (items_reg == win_ext);
    assign out_free = !m_tvalid_reg || m_tready;
    assign sum_zero = (sum_reg == '0);

    // decision from the previous RSI; sell test wins
    always_comb begin
        dec_c = DEC_NONE;
        if (!prior_undef_reg) begin
            if (prior_rsi_reg > {upper_reg, 8'h00}) begin
                dec_c = DEC_SELL;
            end else if (prior_rsi_reg < {lower_reg, 8'h00}) begin
                dec_c = DEC_BUY;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_prime) begin
                    state_next = is_warm ? ST_WARM : ST_MUL_G;
                end
            end
            ST_WARM:    state_next = ST_IDLE;
            ST_MUL_G:   state_next = ST_START_G;
            ST_START_G: state_next = ST_WAIT_G;
            ST_WAIT_G:  if (div_done) state_next = ST_MUL_L;
            ST_MUL_L:   state_next = ST_START_L;
            ST_START_L: state_next = ST_WAIT_L;
            ST_WAIT_L:  if (div_done) state_next = ST_MUL_R;
            ST_MUL_R:   state_next = ST_START_R;
            ST_START_R: state_next = sum_zero ? ST_EMIT : ST_WAIT_R;
            ST_WAIT_R:  if (div_done) state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready        = 1'b0;
        div_req.start   = 1'b0;
        div_req.short_q = 1'b0;
        mul_a           = avg_gain_reg;
        mul_b           = seed_reg ? MB'(1 << AVG_FRAC) : MB'(win_eff - WB'(1));
        gl_sel          = gain_reg;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_START_G: div_req.start = 1'b1;
            ST_MUL_L:   mul_a = avg_loss_reg;
            ST_START_L: begin
                div_req.start = 1'b1;
                gl_sel        = loss_reg;
            end
            ST_MUL_R:   mul_b = MB'(RSI_FULL);
            ST_START_R: begin
                div_req.start   = !sum_zero;
                div_req.short_q = 1'b1;
            end
            default: ;
        endcase
    end

    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    // numerators carry the half-divisor for round half up
    always_comb begin
        if (state_reg == ST_START_R) begin
            div_num = DN'(prod_reg) + DN'(sum_reg >> 1);
            div_den = sum_reg;
        end else begin
            div_num = DN'(prod_reg) + (DN'(gl_sel) << AVG_FRAC) + DN'(win_eff >> 1);
            div_den = DW'(win_eff);
        end
    end

    rsi_divider #(
        .NUM_W  (DN),
        .DEN_W  (DW),
        .QLONG  (QL),
        .QSHORT (RSI_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_len_reg  <= WINDOW_LEN_RESET;
            upper_reg       <= UPPER_RESET;
            lower_reg       <= LOWER_RESET;
            prior_close_reg <= '0;
            items_reg       <= '0;
            avg_gain_reg    <= '0;
            avg_loss_reg    <= '0;
            prior_rsi_reg   <= '0;
            prior_undef_reg <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        prior_close_reg <= close;
                        if (is_prime) begin
                            items_reg <= IW'(1);
                        end else if (is_seed) begin
                            items_reg <= win_ext + IW'(1);
                        end
                    end
                end
                ST_WARM: begin
                    avg_gain_reg <= avg_gain_reg + AVW'(gain_reg);
                    avg_loss_reg <= avg_loss_reg + AVW'(loss_reg);
                    items_reg    <= items_reg + IW'(1);
                end
                ST_WAIT_G: if (div_done) avg_gain_reg <= AVW'(div_quo);
                ST_WAIT_L: if (div_done) avg_loss_reg <= AVW'(div_quo);
                ST_EMIT: begin
                    if (out_free) begin
                        prior_rsi_reg   <= rsi_reg;
                        prior_undef_reg <= undef_reg;
                    end
                end
                default: ;
            endcase

            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_WINDOW_LEN: begin
                        window_len_reg  <= cfg_wr_data;
                        prior_close_reg <= '0;
                        items_reg       <= '0;
                        avg_gain_reg    <= '0;
                        avg_loss_reg    <= '0;
                        prior_rsi_reg   <= '0;
                        prior_undef_reg <= 1'b1;
                    end
                    REG_UPPER_THRESHOLD: upper_reg <= cfg_wr_data[THRESH_W-1:0];
                    REG_LOWER_THRESHOLD: lower_reg <= cfg_wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            gain_reg <= gain_c;
            loss_reg <= loss_c;
            seed_reg <= is_seed;
        end
        if (state_reg == ST_MUL_G || state_reg == ST_MUL_L || state_reg == ST_MUL_R) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_R) begin
            sum_reg <= DW'(avg_gain_reg) + DW'(avg_loss_reg);
        end
        if (state_reg == ST_START_R && sum_zero) begin
            rsi_reg   <= '0;
            undef_reg <= 1'b1;
        end
        if (state_reg == ST_WAIT_R && div_done) begin
            rsi_reg   <= div_quo[RSI_BITS-1:0];
            undef_reg <= 1'b0;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_rsi_reg   <= rsi_reg;
            m_undef_reg <= undef_reg;
            m_dec_reg   <= dec_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - RSI_BITS - DEC_W){1'b0}}, m_dec_reg, m_rsi_reg};
    assign m_tuser  = m_undef_reg;

endmodule

`default_nettype wire

// ===== rtl/rsi_checker.sv =====
`default_nettype none

module rsi_checker import rsi_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    logic in_word;
    assign in_word = s_tvalid && s_tready && (s_tdata == s_tdata);

    // held word stays put until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[RSI_BITS-1:0] == '0)
        else $error("undefined RSI with nonzero value");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RSI_BITS-1:0] <= RSI_FULL
                     && m_tdata[RSI_BITS+DEC_W-1:RSI_BITS] != 2'd3)
        else $error("RSI or decision out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_no_input_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_word && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after an input word");

endmodule

bind rsi_threshold_signal_top rsi_checker u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/tb_rsi_threshold_signal_top.sv =====
`timescale 1ns / 1ps

module tb_rsi_threshold_signal_top;
    import rsi_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 300;     // well past the time one result takes

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [RSI_BITS-1:0] value;
        logic                undef;
        logic [DEC_W-1:0]    dec;
    } rsi_result_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    rsi_threshold_signal_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // RSI predictor: configuration and running state
    // ---------------------------------------------------------------
    logic [CFG_DATA_W-1:0] cfg_window = WINDOW_LEN_RESET;
    logic [THRESH_W-1:0]   cfg_upper  = UPPER_RESET;
    logic [THRESH_W-1:0]   cfg_lower  = LOWER_RESET;

    logic [31:0]         last_close = '0;
    int unsigned         changes_seen = 0;
    logic [63:0]         gain_avg = '0;
    logic [63:0]         loss_avg = '0;
    logic [RSI_BITS-1:0] last_rsi = '0;
    logic                last_undef = 1'b1;

    rsi_result_t   rsi_expected_q[$];
    logic [31:0]   close_q[$];
    int            error_count = 0;

    function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
        return (num + den / 2) / den;
    endfunction

    task automatic enqueue_close(input logic [31:0] price);
        close_q.insert(close_q.size(), price);
    endtask

    task automatic predict_close(input logic [31:0] close);
        logic [63:0]  w, gain, loss, up, dn, total, val;
        logic         undef;
        logic [1:0]   dec;
        rsi_result_t  r;
        w = (cfg_window < 2) ? 64'd2 : 64'(cfg_window);
        if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
        if (changes_seen == 0) begin
            last_close = close;
            changes_seen = 1;
            return;
        end
        gain = (close > last_close) ? 64'(close - last_close) : 64'd0;
        loss = (last_close > close) ? 64'(last_close - close) : 64'd0;
        last_close = close;
        if (changes_seen < w) begin
            // warm-up: plain sums
            gain_avg += gain;
            loss_avg += loss;
            changes_seen++;
            return;
        end
        if (changes_seen == w) begin
            gain_avg = round_div((gain_avg + gain) << AVG_FRAC, w);
            loss_avg = round_div((loss_avg + loss) << AVG_FRAC, w);
            changes_seen = 32'(w + 64'd1);
        end else begin
            gain_avg = round_div(gain_avg * (w - 1) + (gain << AVG_FRAC), w);
            loss_avg = round_div(loss_avg * (w - 1) + (loss << AVG_FRAC), w);
        end

        dec = DEC_NONE;
        if (!last_undef) begin
            if (last_rsi > {cfg_upper, 8'd0})      dec = DEC_SELL;
            else if (last_rsi < {cfg_lower, 8'd0}) dec = DEC_BUY;
        end

        up = gain_avg;
        dn = loss_avg;
        val = 0;
        undef = 1'b1;
        if (up != 0 || dn != 0) begin
            // keep up+dn within 48 bits
            while (((up >> 1) + (dn >> 1) + (up & dn & 64'd1)) >= (64'd1 << 47)) begin
                up >>= 1;
                dn >>= 1;
            end
            total = up + dn;
            if (total != 0) begin
                val = round_div(up * 64'(RSI_FULL), total);
                if (val > 64'(RSI_FULL)) val = 64'(RSI_FULL);
                undef = 1'b0;
            end
        end
        last_rsi = val[RSI_BITS-1:0];
        last_undef = undef;

        r.value = val[RSI_BITS-1:0];
        r.undef = undef;
        r.dec   = dec;
        rsi_expected_q.insert(rsi_expected_q.size(), r);
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Price driver: bursts with random gaps
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_close(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (close_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= close_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor with its own stall pattern
    // ---------------------------------------------------------------
    int ready_mode = 0;
    int ready_left = 0;

    always @(posedge aclk) begin
        rsi_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rsi_expected_q.size() == 0) begin
                    flag_error($sformatf("unexpected word tdata=%h tuser=%h", m_tdata, m_tuser));
                end else begin
                    want = rsi_expected_q.pop_front();
                    if (m_tdata[14:0] !== want.value)
                        flag_error($sformatf("rsi_value got %0d exp %0d",
                                             m_tdata[14:0], want.value));
                    if (m_tdata[16:15] !== want.dec)
                        flag_error($sformatf("decision got %0d exp %0d",
                                             m_tdata[16:15], want.dec));
                    if (m_tuser[0] !== want.undef)
                        flag_error($sformatf("rsi_undefined got %0b exp %0b",
                                             m_tuser[0], want.undef));
                    if (m_tdata[M_TDATA_W-1:17] !== '0)
                        flag_error($sformatf("tdata fill bits nonzero: %h", m_tdata));
                end
            end
            if (ready_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                ready_left = $urandom_range(20, 400);
            end else begin
                ready_left--;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rsi_threshold_signal_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WINDOW_LEN: begin
                // window write restarts the indicator, thresholds stay
                cfg_window   = val;
                last_close   = '0;
                changes_seen = 0;
                gain_avg     = '0;
                loss_avg     = '0;
                last_rsi     = '0;
                last_undef   = 1'b1;
            end
            REG_UPPER_THRESHOLD: cfg_upper = val[THRESH_W-1:0];
            REG_LOWER_THRESHOLD: cfg_lower = val[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (close_q.size() != 0 || s_tvalid || rsi_expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // well-formed price walks with random segments of noise, flats and extremes
    task automatic queue_random_prices(input int count);
        logic [31:0] price, step, mask;
        int          mode, seg_left, step_bits, up_pct;
        price = $urandom;
        seg_left = 0;
        mode = 0;
        up_pct = 50;
        repeat (count) begin
            if (seg_left == 0) begin
                mode      = $urandom_range(0, 9);
                seg_left  = $urandom_range(5, 60);
                step_bits = $urandom_range(1, 32);
                up_pct    = 25 * $urandom_range(0, 4);
            end
            seg_left--;
            mask = (step_bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << step_bits) - 1);
            case (mode)
                0: begin
                    case ($urandom_range(0, 3))
                        0:       price = 32'h0;
                        1:       price = 32'hFFFF_FFFF;
                        default: price = $urandom;
                    endcase
                end
                1: ;    // flat
                default: begin
                    step = $urandom & mask;
                    if ($urandom_range(0, 99) < up_pct) price = price + step;
                    else                                price = price - step;
                end
            endcase
            enqueue_close(price);
        end
    endtask

    initial begin
        int          count;
        logic [7:0]  window, upper, lower;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // window 1 acts as 2; thresholds at the extremes so equal RSI gives none;
        // flat start gives an undefined RSI, then full-scale swings
        write_reg(REG_WINDOW_LEN, 8'd1);
        write_reg(REG_UPPER_THRESHOLD, 8'd100);
        write_reg(REG_LOWER_THRESHOLD, 8'd0);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'hFFFF_FFFF);
        enqueue_close(32'hFFFF_FFFF);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'h0000_0000);
        wait_drained();

        // window 0 acts as 2; crossed thresholds, sell wins; unused index ignored
        write_reg(REG_WINDOW_LEN, 8'd0);
        write_reg(REG_UPPER_THRESHOLD, 8'd20);
        write_reg(REG_LOWER_THRESHOLD, 8'd80);
        write_reg(REG_UNUSED, 8'hA5);
        enqueue_close(32'd100);
        enqueue_close(32'd200);
        enqueue_close(32'd100);
        enqueue_close(32'd200);
        enqueue_close(32'd100);
        wait_drained();

        // thresholds above 100 with bit 7 set in the written value: buy only
        write_reg(REG_WINDOW_LEN, 8'd2);
        write_reg(REG_UPPER_THRESHOLD, 8'hE5);
        write_reg(REG_LOWER_THRESHOLD, 8'hFF);
        enqueue_close(32'hFFFF_FFFF);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'h0000_0000);
        enqueue_close(32'h0000_0001);
        enqueue_close(32'h8000_0000);
        enqueue_close(32'h7FFF_FFFF);
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: window = WINDOW_LEN_RESET;
                1: window = 8'd255;
                2: window = 8'd2;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       window = 8'($urandom_range(0, 1));
                        1, 2, 3: window = 8'($urandom_range(9, 40));
                        default: window = 8'($urandom_range(2, 8));
                    endcase
                end
            endcase
            case (phase)
                2:       begin upper = 8'd0;   lower = 8'd0;   end
                3:       begin upper = 8'd100; lower = 8'd100; end
                default: begin
                    upper = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(40, 100));
                    lower = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 60));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(REG_WINDOW_LEN, window);
                write_reg(REG_UPPER_THRESHOLD, upper);
                write_reg(REG_LOWER_THRESHOLD, lower);
            end else begin
                write_reg(REG_LOWER_THRESHOLD, lower);
                if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 8'($urandom));
                write_reg(REG_UPPER_THRESHOLD, upper);
                write_reg(REG_WINDOW_LEN, window);
            end
            count = ((window < 2) ? 2 : window) + 1 + $urandom_range(100, 170);
            queue_random_prices(count);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb_rsi_threshold_signal_top passed");
        end else begin
            $display("tb_rsi_threshold_signal_top failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rsi_pkg.sv
rtl/rsi_divider.sv
rtl/rsi_threshold_signal_top.sv
rtl/rsi_checker.sv
dv/tb_rsi_threshold_signal_top.sv
